[rtl/gasp_pkg.sv]
// Shared types, codes and constants for the grid path search block.
package gasp_pkg;

   // Fixed field widths
   localparam int COORD_W  = 6;
   localparam int COST_W   = 21;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 7;
   // Width for comparing a coordinate against any grid bound up to 256
   localparam int CMP_W    = 9;

   localparam logic [COST_W-1:0] COST_SAT = 21'h1FFFFF;

   // Result status codes
   localparam logic [STATUS_W-1:0] RES_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] RES_BAD_START = 2'd1;
   localparam logic [STATUS_W-1:0] RES_BAD_GOAL  = 2'd2;
   localparam logic [STATUS_W-1:0] RES_NO_PATH   = 2'd3;

   // Per-cell search marks
   localparam logic [1:0] MARK_NONE   = 2'd0;
   localparam logic [1:0] MARK_OPEN   = 2'd1;
   localparam logic [1:0] MARK_CLOSED = 2'd2;

   // Neighbor offset codes
   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   // Datapath commands
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
   localparam logic [OP_W-1:0] OP_LATCH    = 4'd2;
   localparam logic [OP_W-1:0] OP_RD_START = 4'd3;
   localparam logic [OP_W-1:0] OP_RD_GOAL  = 4'd4;
   localparam logic [OP_W-1:0] OP_CLEAR    = 4'd5;
   localparam logic [OP_W-1:0] OP_SEED     = 4'd6;
   localparam logic [OP_W-1:0] OP_SCAN     = 4'd7;
   localparam logic [OP_W-1:0] OP_CLOSE    = 4'd8;
   localparam logic [OP_W-1:0] OP_NB_RD    = 4'd9;
   localparam logic [OP_W-1:0] OP_NB_EVAL  = 4'd10;
   localparam logic [OP_W-1:0] OP_RESULT   = 4'd11;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] code;
   } gasp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_func;
      logic start_ok;
      logic goal_ok;
      logic cnt_last;
      logic found_any;
      logic best_is_goal;
      logic nb_last;
      logic rsp_busy;
   } gasp_stat_type;

   // x offset of neighbor d
   function automatic logic [1:0] nb_dx(input logic [2:0] d);
      logic [1:0] r;
      case (d)
         3'd0, 3'd1, 3'd2: r = OFF_MINUS;
         3'd3, 3'd4:       r = OFF_ZERO;
         default:          r = OFF_PLUS;
      endcase
      return r;
   endfunction

   // y offset of neighbor d
   function automatic logic [1:0] nb_dy(input logic [2:0] d);
      logic [1:0] r;
      case (d)
         3'd0, 3'd3, 3'd5: r = OFF_MINUS;
         3'd1, 3'd6:       r = OFF_ZERO;
         default:          r = OFF_PLUS;
      endcase
      return r;
   endfunction

   // round(sqrt(2) * 2^frac), evaluated at elaboration
   function automatic int unsigned diag_step(input int unsigned frac);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = 64'd2 << (2 * frac);
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 64'd0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (n > r) r = r + 64'd1;
      return 32'(r);
   endfunction

endpackage

[rtl/gasp_req_if.sv]
// Request channel interface: valid/ready handshake with the request payload.
interface gasp_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [5:0] cell_x;
   logic [5:0] cell_y;
   logic       occupied;
   logic [5:0] goal_x;
   logic [5:0] goal_y;

   modport source (output valid, func, cell_x, cell_y, occupied, goal_x, goal_y,
                   input ready);
   modport sink   (input valid, func, cell_x, cell_y, occupied, goal_x, goal_y,
                   output ready);
endinterface

[rtl/gasp_rsp_if.sv]
// Response channel interface: valid/ready handshake with status and path cost.
interface gasp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [20:0] path_cost;

   modport source (output valid, status, path_cost, input ready);
   modport sink   (input valid, status, path_cost, output ready);
endinterface

[rtl/gasp_ctrl.sv]
// Search sequencer: steps the datapath through checks, clear, scan and expansion.
module gasp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  gasp_pkg::gasp_stat_type stat,
   output gasp_pkg::gasp_cmd_type  cmd,
   output logic                    req_ready
);
   import gasp_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHK_S   = 4'd1;
   localparam logic [3:0] S_CHK_S2  = 4'd2;
   localparam logic [3:0] S_CHK_G   = 4'd3;
   localparam logic [3:0] S_CLEAR   = 4'd4;
   localparam logic [3:0] S_SEED    = 4'd5;
   localparam logic [3:0] S_SCAN    = 4'd6;
   localparam logic [3:0] S_TAIL    = 4'd7;
   localparam logic [3:0] S_DECIDE  = 4'd8;
   localparam logic [3:0] S_NB_RD   = 4'd9;
   localparam logic [3:0] S_NB_EVAL = 4'd10;
   localparam logic [3:0] S_RESULT  = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   // next state and command
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd.op    = OP_NOP;
      cmd.code  = code_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (stat.req_valid) begin
               if (stat.req_func) begin
                  cmd.op   = OP_LATCH;
                  state_in = S_CHK_S;
               end else begin
                  cmd.op = OP_LOAD;
               end
            end
         end
         S_CHK_S: begin
            cmd.op   = OP_RD_START;
            state_in = S_CHK_S2;
         end
         S_CHK_S2: begin
            if (!stat.start_ok) begin
               code_in  = RES_BAD_START;
               state_in = S_RESULT;
            end else begin
               cmd.op   = OP_RD_GOAL;
               state_in = S_CHK_G;
            end
         end
         S_CHK_G: begin
            if (!stat.goal_ok) begin
               code_in  = RES_BAD_GOAL;
               state_in = S_RESULT;
            end else begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.cnt_last) state_in = S_SEED;
         end
         S_SEED: begin
            cmd.op   = OP_SEED;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.cnt_last) state_in = S_TAIL;
         end
         S_TAIL: begin
            // last scan read is compared this cycle
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!stat.found_any) begin
               code_in  = RES_NO_PATH;
               state_in = S_RESULT;
            end else if (stat.best_is_goal) begin
               code_in  = RES_FOUND;
               state_in = S_RESULT;
            end else begin
               cmd.op   = OP_CLOSE;
               state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            cmd.op   = OP_NB_RD;
            state_in = S_NB_EVAL;
         end
         S_NB_EVAL: begin
            cmd.op   = OP_NB_EVAL;
            state_in = stat.nb_last ? S_SCAN : S_NB_RD;
         end
         S_RESULT: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= RES_NO_PATH;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

[rtl/gasp_datapath.sv]
// Search datapath: occupancy and node memories, scan compare, neighbor cost update.
module gasp_datapath #(
   parameter int MAX_X     = 64,
   parameter int MAX_Y     = 64,
   parameter int FRAC_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gasp_pkg::gasp_cmd_type               cmd,
   output gasp_pkg::gasp_stat_type              stat,
   input  logic [gasp_pkg::SIZE_W-1:0]          grid_width,
   input  logic [gasp_pkg::SIZE_W-1:0]          grid_height,
   input  logic                                 req_valid,
   input  logic                                 req_func,
   input  logic [gasp_pkg::COORD_W-1:0]         req_cell_x,
   input  logic [gasp_pkg::COORD_W-1:0]         req_cell_y,
   input  logic                                 req_occupied,
   input  logic [gasp_pkg::COORD_W-1:0]         req_goal_x,
   input  logic [gasp_pkg::COORD_W-1:0]         req_goal_y,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [gasp_pkg::STATUS_W-1:0]        rsp_status,
   output logic [gasp_pkg::COST_W-1:0]          rsp_path_cost
);
   import gasp_pkg::*;

   localparam int XW    = $clog2(MAX_X);
   localparam int YW    = $clog2(MAX_Y);
   localparam int OW    = (XW > YW) ? XW : YW;
   localparam int AW    = XW + YW;
   localparam int CELLS = 1 << AW;
   localparam int unsigned DIAG = diag_step(FRAC_BITS);
   localparam int DGW   = FRAC_BITS + 2;
   localparam int CW    = AW + FRAC_BITS + 2;
   localparam int SW    = (CW > COST_W) ? CW : COST_W;
   localparam int NW    = 2 + 2 * CW;

   localparam logic [CW-1:0] STEP_ONE  = CW'(1) << FRAC_BITS;
   localparam logic [CW-1:0] STEP_DIAG = CW'(DIAG);

   // memories
   logic          obs_mem  [CELLS];
   logic [NW-1:0] node_mem [CELLS];

   logic          obs_we, obs_wd, obs_rd_ff;
   logic [AW-1:0] obs_wa, obs_ra;
   logic          node_we;
   logic [AW-1:0] node_wa, node_ra;
   logic [NW-1:0] node_wd, node_rd_ff;

   // search registers
   logic [COORD_W-1:0] sx_ff, sy_ff, gx_ff, gy_ff;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      addr_d_ff;
   logic               pend_ff;
   logic               found_ff, found_in;
   logic [AW-1:0]      best_ff, best_in;
   logic [CW-1:0]      best_g_ff, best_g_in, best_f_ff, best_f_in;
   logic [2:0]         nb_ff, nb_in;
   logic               nb_ok_ff, diag_ff;
   logic [AW-1:0]      n_ff;
   logic [CW-1:0]      h_ff;
   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COST_W-1:0]  rsp_cost_ff;

   // grid bounds in use
   logic [CMP_W-1:0] w9, h9;
   assign w9 = ({2'b00, grid_width} > CMP_W'(MAX_X)) ? CMP_W'(MAX_X) : {2'b00, grid_width};
   assign h9 = ({2'b00, grid_height} > CMP_W'(MAX_Y)) ? CMP_W'(MAX_Y) : {2'b00, grid_height};

   logic [AW-1:0] s_addr, g_addr;
   assign s_addr = {YW'(sy_ff), XW'(sx_ff)};
   assign g_addr = {YW'(gy_ff), XW'(gx_ff)};

   logic ld_ok, start_in, goal_in;
   assign ld_ok    = (CMP_W'(req_cell_x) < CMP_W'(MAX_X)) && (CMP_W'(req_cell_y) < CMP_W'(MAX_Y));
   assign start_in = (CMP_W'(sx_ff) < w9) && (CMP_W'(sy_ff) < h9);
   assign goal_in  = (CMP_W'(gx_ff) < w9) && (CMP_W'(gy_ff) < h9);

   // node word read back
   logic [1:0]    rd_mark;
   logic [CW-1:0] rd_g, rd_f;
   assign rd_mark = node_rd_ff[NW-1:NW-2];
   assign rd_g    = node_rd_ff[2*CW-1:CW];
   assign rd_f    = node_rd_ff[CW-1:0];

   // neighbor of the expanded cell
   logic [XW-1:0]    cx, nx;
   logic [YW-1:0]    cy, ny;
   logic [1:0]       dxc, dyc;
   logic [CMP_W-1:0] nx9, ny9;
   logic [AW-1:0]    n_addr;
   logic             nb_in_grid, nb_diag;
   assign cx  = best_ff[XW-1:0];
   assign cy  = best_ff[AW-1:XW];
   assign dxc = nb_dx(nb_ff);
   assign dyc = nb_dy(nb_ff);
   always_comb begin
      case (dxc)
         OFF_MINUS: nx9 = CMP_W'(cx) - CMP_W'(1);
         OFF_PLUS:  nx9 = CMP_W'(cx) + CMP_W'(1);
         default:   nx9 = CMP_W'(cx);
      endcase
      case (dyc)
         OFF_MINUS: ny9 = CMP_W'(cy) - CMP_W'(1);
         OFF_PLUS:  ny9 = CMP_W'(cy) + CMP_W'(1);
         default:   ny9 = CMP_W'(cy);
      endcase
   end
   // a step below zero wraps high and fails the bound compare
   assign nb_in_grid = (nx9 < w9) && (ny9 < h9);
   assign nx         = nx9[XW-1:0];
   assign ny         = ny9[YW-1:0];
   assign n_addr     = {ny, nx};
   assign nb_diag    = (dxc != OFF_ZERO) && (dyc != OFF_ZERO);

   // octile distance to the goal, shared by seed and neighbor
   logic [OW-1:0]     ox, oy, ogx, ogy, adx, ady, lo, hi;
   logic [OW+DGW-1:0] prod;
   logic [CW-1:0]     oct;
   assign ox   = (cmd.op == OP_SEED) ? OW'(sx_ff) : OW'(nx);
   assign oy   = (cmd.op == OP_SEED) ? OW'(sy_ff) : OW'(ny);
   assign ogx  = OW'(gx_ff);
   assign ogy  = OW'(gy_ff);
   assign adx  = (ox > ogx) ? ox - ogx : ogx - ox;
   assign ady  = (oy > ogy) ? oy - ogy : ogy - oy;
   assign lo   = (adx < ady) ? adx : ady;
   assign hi   = (adx < ady) ? ady : adx;
   assign prod = (OW+DGW)'(lo) * (OW+DGW)'(DIAG);
   assign oct  = (CW'(hi - lo) << FRAC_BITS) + CW'(prod);

   // neighbor cost update
   logic [CW-1:0] g_new;
   logic          nb_upd;
   assign g_new  = best_g_ff + (diag_ff ? STEP_DIAG : STEP_ONE);
   assign nb_upd = nb_ok_ff && !obs_rd_ff && (rd_mark != MARK_CLOSED) &&
                   ((rd_mark == MARK_NONE) || (g_new < rd_g));

   // scan compare on the registered read
   logic scan_take;
   assign scan_take = pend_ff && (rd_mark == MARK_OPEN) && (!found_ff || (rd_f < best_f_ff));

   // saturated cost
   logic [SW-1:0]     cost_ext;
   logic [COST_W-1:0] cost_sat;
   assign cost_ext = SW'(best_g_ff);
   assign cost_sat = (cost_ext > SW'(COST_SAT)) ? COST_SAT : cost_ext[COST_W-1:0];

   // memory port selection
   always_comb begin
      obs_we  = 1'b0;
      obs_wa  = {YW'(req_cell_y), XW'(req_cell_x)};
      obs_wd  = req_occupied;
      obs_ra  = n_addr;
      node_we = 1'b0;
      node_wa = cnt_ff;
      node_wd = {MARK_NONE, {CW{1'b0}}, {CW{1'b0}}};
      node_ra = cnt_ff;
      case (cmd.op)
         OP_LOAD:     obs_we = ld_ok;
         OP_RD_START: obs_ra = s_addr;
         OP_RD_GOAL:  obs_ra = g_addr;
         OP_CLEAR:    node_we = 1'b1;
         OP_SEED: begin
            node_we = 1'b1;
            node_wa = s_addr;
            node_wd = {MARK_OPEN, {CW{1'b0}}, oct};
         end
         OP_CLOSE: begin
            node_we = 1'b1;
            node_wa = best_ff;
            node_wd = {MARK_CLOSED, best_g_ff, best_f_ff};
         end
         OP_NB_RD: node_ra = n_addr;
         OP_NB_EVAL: begin
            node_we = nb_upd;
            node_wa = n_ff;
            node_wd = {MARK_OPEN, g_new, g_new + h_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (obs_we) obs_mem[obs_wa] <= obs_wd;
      obs_rd_ff <= obs_mem[obs_ra];
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_wa] <= node_wd;
      node_rd_ff <= node_mem[node_ra];
   end

   // counters and best tracking
   always_comb begin
      cnt_in    = cnt_ff;
      nb_in     = nb_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      best_g_in = best_g_ff;
      best_f_in = best_f_ff;
      if (scan_take) begin
         found_in  = 1'b1;
         best_in   = addr_d_ff;
         best_g_in = rd_g;
         best_f_in = rd_f;
      end
      case (cmd.op)
         OP_LATCH:   cnt_in = '0;
         OP_CLEAR:   cnt_in = cnt_ff + AW'(1);
         OP_SCAN:    cnt_in = cnt_ff + AW'(1);
         OP_NB_EVAL: nb_in  = nb_ff + 3'd1;
         OP_SEED: begin
            cnt_in   = '0;
            found_in = 1'b0;
         end
         OP_CLOSE: begin
            cnt_in   = '0;
            found_in = 1'b0;
            nb_in    = 3'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         nb_ff    <= 3'd0;
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         nb_ff    <= nb_in;
         found_ff <= found_in;
         pend_ff  <= (cmd.op == OP_SCAN);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_ff   <= best_in;
      best_g_ff <= best_g_in;
      best_f_ff <= best_f_in;
      addr_d_ff <= cnt_ff;
      if (cmd.op == OP_LATCH) begin
         sx_ff <= req_cell_x;
         sy_ff <= req_cell_y;
         gx_ff <= req_goal_x;
         gy_ff <= req_goal_y;
      end
      if (cmd.op == OP_NB_RD) begin
         nb_ok_ff <= nb_in_grid;
         n_ff     <= n_addr;
         h_ff     <= oct;
         diag_ff  <= nb_diag;
      end
      if (cmd.op == OP_RESULT) begin
         rsp_status_ff <= cmd.code;
         rsp_cost_ff   <= (cmd.code == RES_FOUND) ? cost_sat : {COST_W{1'b0}};
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_path_cost = rsp_cost_ff;

   // status to the sequencer
   always_comb begin
      stat.req_valid    = req_valid;
      stat.req_func     = req_func;
      stat.start_ok     = start_in && !obs_rd_ff;
      stat.goal_ok      = goal_in && !obs_rd_ff;
      stat.cnt_last     = (cnt_ff == {AW{1'b1}});
      stat.found_any    = found_ff;
      stat.best_is_goal = (best_ff == g_addr);
      stat.nb_last      = (nb_ff == 3'd7);
      stat.rsp_busy     = rsp_valid_ff;
   end

endmodule

[rtl/grid_astar_path_search.sv]
// Top level of the grid A* path search: CSR block, sequencer and datapath.
//
//  channel  | dir | handshake          | carries
//  ---------+-----+--------------------+------------------------------------------
//  req_chan | in  | valid/ready        | func, cell_x, cell_y, occupied, goal_x/y
//  rsp_chan | out | valid/ready        | status, path_cost
//  csr_*    | in  | APB psel/penable   | grid_width (0x0), grid_height (0x4)
//
//  A load request is written to the occupancy memory in the idle state, which stays
//  ready for the next request. A search with a good start and goal first clears all
//  N = 2^(clog2(MAX_X)+clog2(MAX_Y)) node entries (4096 by default); each search round
//  then scans all N entries on the node memory's single read port, and each expansion
//  adds eight neighbor updates. A bad start or a bad goal answers with no clearing pass.
//  Reset is synchronous; a finished response waits in its output register while
//  the next request is taken, and a further search waits there for rsp_chan.ready.
module grid_astar_path_search #(
   parameter int MAX_X     = 64,
   parameter int MAX_Y     = 64,
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   gasp_req_if.sink    req_chan,
   gasp_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gasp_pkg::*;

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   logic [SIZE_W-1:0] grid_width_ff, grid_height_ff;
   logic              csr_wr;
   gasp_cmd_type      cmd;
   gasp_stat_type     stat;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 7'd6;
         grid_height_ff <= 7'd7;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_IDX_WIDTH)  grid_width_ff  <= csr_pwdata[SIZE_W-1:0];
         if (csr_paddr[2] == CSR_IDX_HEIGHT) grid_height_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_HEIGHT) ? {25'd0, grid_height_ff}
                                                        : {25'd0, grid_width_ff};

   // sequencer
   gasp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_chan.ready)
   );

   // datapath
   gasp_datapath #(
      .MAX_X     (MAX_X),
      .MAX_Y     (MAX_Y),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .grid_width    (grid_width_ff),
      .grid_height   (grid_height_ff),
      .req_valid     (req_chan.valid),
      .req_func      (req_chan.func),
      .req_cell_x    (req_chan.cell_x),
      .req_cell_y    (req_chan.cell_y),
      .req_occupied  (req_chan.occupied),
      .req_goal_x    (req_chan.goal_x),
      .req_goal_y    (req_chan.goal_y),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_status    (rsp_chan.status),
      .rsp_path_cost (rsp_chan.path_cost)
   );

`ifndef NO_ASSERTIONS
   // a load request never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !req_chan.func && !rsp_chan.valid)
      |=> !rsp_chan.valid)
      else $error("load request produced a response");

   // an accepted search holds off further requests
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.func) |=> !req_chan.ready)
      else $error("request taken while a search runs");

   // cost is zero unless a path was found
   a_cost_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != RES_FOUND)) |-> (rsp_chan.path_cost == 21'd0))
      else $error("nonzero cost without a path");
`endif

endmodule

[dv/grid_astar_path_search_test.sv]
// Self-checking testbench for the grid A* path search block.
module grid_astar_path_search_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gasp_pkg::*;

   localparam int GRID_DIM  = 64;
   localparam int CELL_CNT  = GRID_DIM * GRID_DIM;
   // region preloaded as free: covers every cell a search here can read
   localparam int LOAD_W    = 6;
   localparam int LOAD_H    = 7;
   localparam longint STEP_ONE  = 256;
   localparam longint STEP_DIAG = 362;
   localparam int REG_GRID_WIDTH  = 0;
   localparam int REG_GRID_HEIGHT = 1;
   localparam bit FUNC_LOAD   = 1'b0;
   localparam bit FUNC_SEARCH = 1'b1;
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      bit       func;
      bit [5:0] x;
      bit [5:0] y;
      bit       occ;
      bit [5:0] gx;
      bit [5:0] gy;
   } grid_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [COST_W-1:0]   cost;
   } route_type;

   typedef struct {
      grid_req_type item;
      bit           fixed;
      route_type    res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gasp_req_if req ();
   gasp_rsp_if rsp ();

   grid_astar_path_search DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req),
      .rsp_chan   (rsp),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #10 clock = ~clock;

   // Shadow state of the block
   bit          obstacle[CELL_CNT];
   int          cfg_width = 6;
   int          cfg_height = 7;
   route_type   pending_routes[$];
   int          errors = 0;
   int          n_loads = 0;
   int          n_searches = 0;
   bit          no_idle = 1'b0;
   dir_row_type steps[$];

   function automatic longint octile(int ax, int ay, int bx, int by);
      int dx, dy, lo, hi;
      dx = ax > bx ? ax - bx : bx - ax;
      dy = ay > by ? ay - by : by - ay;
      lo = dx < dy ? dx : dy;
      hi = dx < dy ? dy : dx;
      return longint'(hi - lo) * STEP_ONE + longint'(lo) * STEP_DIAG;
   endfunction

   // Optimal route cost over the shadow map
   function automatic route_type plan_route(int sx, int sy, int gx, int gy);
      int w, h, best, cx, cy, nx, ny, n, k;
      bit [1:0] mark[CELL_CNT];
      longint g_cost[CELL_CNT];
      longint f_cost[CELL_CNT];
      longint ng;
      route_type r;
      w = cfg_width < GRID_DIM ? cfg_width : GRID_DIM;
      h = cfg_height < GRID_DIM ? cfg_height : GRID_DIM;
      r.status = RES_NO_PATH;
      r.cost = '0;
      if (sx >= w || sy >= h || obstacle[sy*GRID_DIM+sx]) begin
         r.status = RES_BAD_START;
         return r;
      end
      if (gx >= w || gy >= h || obstacle[gy*GRID_DIM+gx]) begin
         r.status = RES_BAD_GOAL;
         return r;
      end
      foreach (mark[i]) mark[i] = MARK_NONE;
      mark[sy*GRID_DIM+sx] = MARK_OPEN;
      g_cost[sy*GRID_DIM+sx] = 0;
      f_cost[sy*GRID_DIM+sx] = octile(sx, sy, gx, gy);
      while (1'b1) begin
         best = -1;
         for (k = 0; k < CELL_CNT; k++)
            if (mark[k] == MARK_OPEN && (best < 0 || f_cost[k] < f_cost[best])) best = k;
         if (best < 0) break;
         mark[best] = MARK_CLOSED;
         cx = best % GRID_DIM;
         cy = best / GRID_DIM;
         if (cx == gx && cy == gy) begin
            r.status = RES_FOUND;
            r.cost = g_cost[best] > COST_SAT ? COST_SAT : g_cost[best][COST_W-1:0];
            break;
         end
         for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
               nx = cx + dx;
               ny = cy + dy;
               if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
               n = ny * GRID_DIM + nx;
               if (obstacle[n] || mark[n] == MARK_CLOSED) continue;
               ng = g_cost[best] + ((dx != 0 && dy != 0) ? STEP_DIAG : STEP_ONE);
               if (mark[n] == MARK_NONE || ng < g_cost[n]) begin
                  mark[n] = MARK_OPEN;
                  g_cost[n] = ng;
                  f_cost[n] = ng + octile(nx, ny, gx, gy);
               end
            end
         end
      end
      return r;
   endfunction

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   // Send one request; on acceptance update the shadow map or queue the route
   task automatic issue(input grid_req_type it, input bit fixed, input route_type fixed_res);
      int gap;
      route_type exp_r;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.func     <= it.func;
      req.cell_x   <= it.x;
      req.cell_y   <= it.y;
      req.occupied <= it.occ;
      req.goal_x   <= it.gx;
      req.goal_y   <= it.gy;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (it.func == FUNC_LOAD) begin
         obstacle[it.y*GRID_DIM+it.x] = it.occ;
         n_loads++;
      end else begin
         exp_r = fixed ? fixed_res : plan_route(it.x, it.y, it.gx, it.gy);
         pending_routes = {pending_routes, exp_r};
         n_searches++;
      end
   endtask

   task automatic send(input grid_req_type it);
      route_type none;
      none = '{RES_FOUND, '0};
      issue(it, 1'b0, none);
   endtask

   task automatic csr_write(input int index, input int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (index == REG_GRID_WIDTH) cfg_width = value & 'h7F;
      else if (index == REG_GRID_HEIGHT) cfg_height = value & 'h7F;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input int w, input int h);
      drain();
      csr_write(REG_GRID_WIDTH, w);
      csr_write(REG_GRID_HEIGHT, h);
   endtask

   task automatic add_step(input dir_row_type r);
      steps = {steps, r};
   endtask

   function automatic grid_req_type mk(bit f, int x, int y, bit o, int gx, int gy);
      grid_req_type it;
      it = '{f, 6'(x), 6'(y), o, 6'(gx), 6'(gy)};
      return it;
   endfunction

   function automatic dir_row_type row(grid_req_type it, bit fixed, logic [1:0] st, int cost);
      dir_row_type r;
      r.item = it;
      r.fixed = fixed;
      r.res = '{st, 21'(cost)};
      return r;
   endfunction

   // Result side: random stalls, compare with the oldest queued route
   initial begin
      int stall;
      route_type exp_r;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         if (pending_routes.size() == 0) begin
            report($sformatf("unexpected result status=%0d cost=%0d",
                             rsp.status, rsp.path_cost));
         end else begin
            exp_r = pending_routes.pop_front();
            if (rsp.status !== exp_r.status)
               report($sformatf("status %0d, expected %0d", rsp.status, exp_r.status));
            if (rsp.path_cost !== exp_r.cost)
               report($sformatf("path_cost %0d, expected %0d", rsp.path_cost, exp_r.cost));
         end
      end
   end

   // Main stimulus
   initial begin
      grid_req_type it;
      int w, h, pick;
      int sizes_w[7] = '{1, 2, 1, 3, 4, 5, 2};
      int sizes_h[7] = '{1, 1, 5, 3, 5, 5, 4};
      req.valid <= 1'b0;
      req.func <= 1'b0;
      req.cell_x <= '0;
      req.cell_y <= '0;
      req.occupied <= 1'b0;
      req.goal_x <= '0;
      req.goal_y <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Free every cell a search can reach so none reads an unwritten one
      no_idle = 1'b1;
      for (int y = 0; y < LOAD_H; y++)
         for (int x = 0; x < LOAD_W; x++) send(mk(FUNC_LOAD, x, y, 1'b0, 0, 0));
      no_idle = 1'b0;

      // Directed table on the reset grid size
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 0, 0), 1, RES_FOUND, 0));
      add_step(row(mk(FUNC_SEARCH, 5, 6, 1, 5, 6), 1, RES_FOUND, 0));
      add_step(row(mk(FUNC_SEARCH, 6, 0, 0, 0, 0), 1, RES_BAD_START, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 7, 0, 0, 0), 1, RES_BAD_START, 0));
      add_step(row(mk(FUNC_SEARCH, 63, 63, 0, 63, 63), 1, RES_BAD_START, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 6, 0), 1, RES_BAD_GOAL, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 63, 63), 1, RES_BAD_GOAL, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 1, 0), 1, RES_FOUND, 256));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 1, 1), 1, RES_FOUND, 362));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 5, 5), 1, RES_FOUND, 1810));
      add_step(row(mk(FUNC_LOAD, 2, 2, 1, 63, 63), 0, RES_FOUND, 0));
      add_step(row(mk(FUNC_SEARCH, 2, 2, 0, 0, 0), 1, RES_BAD_START, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 2, 2), 1, RES_BAD_GOAL, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 4, 4), 0, RES_FOUND, 0));
      // outside the grid in use, but stored
      add_step(row(mk(FUNC_LOAD, 63, 63, 1, 0, 0), 0, RES_FOUND, 0));
      add_step(row(mk(FUNC_LOAD, 63, 63, 0, 0, 0), 0, RES_FOUND, 0));
      // full wall at x = 3 cuts the grid in two
      for (int y = 0; y < 7; y++)
         add_step(row(mk(FUNC_LOAD, 3, y, 1, 0, 0), 0, RES_FOUND, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 5, 0), 1, RES_NO_PATH, 0));
      add_step(row(mk(FUNC_LOAD, 3, 3, 0, 0, 0), 0, RES_FOUND, 0));
      add_step(row(mk(FUNC_LOAD, 2, 2, 0, 0, 0), 0, RES_FOUND, 0));
      add_step(row(mk(FUNC_SEARCH, 0, 0, 0, 5, 0), 0, RES_FOUND, 0));
      foreach (steps[i]) issue(steps[i].item, steps[i].fixed, steps[i].res);

      // Oversized grid clamps to the full 64 x 64 area
      set_grid(127, 64);
      send(mk(FUNC_LOAD, 63, 63, 1, 0, 0));
      send(mk(FUNC_SEARCH, 0, 0, 0, 63, 63));
      send(mk(FUNC_SEARCH, 63, 63, 0, 0, 0));
      // diagonal through the wall gap stays inside the preloaded corner
      send(mk(FUNC_SEARCH, 0, 0, 0, 5, 5));
      send(mk(FUNC_SEARCH, 3, 0, 0, 0, 0));

      // Empty grid: every search has a bad start
      set_grid(0, 0);
      for (int i = 0; i < 5; i++)
         send(mk(FUNC_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63)));

      // Random phases on small grids
      for (int p = 0; p < 6; p++) begin
         pick = $urandom_range(0, 6);
         set_grid(sizes_w[pick], sizes_h[pick]);
         w = sizes_w[pick];
         h = sizes_h[pick];
         no_idle = (p == 3);
         for (int i = 0; i < 6; i++) begin
            if (p == 1 && i == 3) begin
               req.valid <= 1'b0;
               while (pending_routes.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 99) < 65) begin
               if ($urandom_range(0, 4) != 0)
                  it = mk(FUNC_LOAD, $urandom_range(0, w-1), $urandom_range(0, h-1),
                          $urandom_range(0, 99) < 30, $urandom_range(0, 63),
                          $urandom_range(0, 63));
               else
                  it = mk(FUNC_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1), $urandom_range(0, 63),
                          $urandom_range(0, 63));
            end else if ($urandom_range(0, 99) < 85) begin
               it = mk(FUNC_SEARCH, $urandom_range(0, w-1), $urandom_range(0, h-1),
                       $urandom_range(0, 1), $urandom_range(0, w-1), $urandom_range(0, h-1));
            end else begin
               it = mk(FUNC_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63));
            end
            send(it);
         end
      end
      no_idle = 1'b0;
      drain();

      $display("run covered %0d cell loads and %0d searches over several grid sizes",
               n_loads, n_searches);
      $display("including empty, small and oversized grids, walls and blocked endpoints");
      if (errors == 0) begin
         $display("[grid_astar_path_search] OK");
      end else begin
         $display("[grid_astar_path_search] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000_000;
      $display("[grid_astar_path_search] ERROR");
      $finish;
   end

endmodule
